// ===== src/upsc_pkg.sv =====
// ----------------------------------------------------------------------------
// upsc_pkg
// Shared types and action codes for the udp payload signature classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package upsc_pkg;

  typedef struct packed {
    logic       is_udp;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       last_byte;
  } upsc_in_t;

  typedef struct packed {
    logic       excluded;
    logic       detected;
    logic [7:0] action_code;
  } upsc_out_t;

  // per-packet flags handed from the byte tracker to the rule check
  typedef struct packed {
    logic [7:0] first_byte;
    logic       second_byte_large;
    logic       offset3_bad;
    logic       offset8_bad;
    logic       tick_field_bad;
    logic       udp_seen;
  } upsc_flags_t;

  localparam logic [7:0] ACT_T0  = 8'd0;
  localparam logic [7:0] ACT_T1  = 8'd1;
  localparam logic [7:0] ACT_T2  = 8'd2;
  localparam logic [7:0] ACT_T3  = 8'd3;
  localparam logic [7:0] ACT_T4  = 8'd4;
  localparam logic [7:0] ACT_T5  = 8'd5;
  localparam logic [7:0] ACT_T6  = 8'd6;
  localparam logic [7:0] ACT_T7  = 8'd7;
  localparam logic [7:0] ACT_T8  = 8'd8;
  localparam logic [7:0] ACT_T9  = 8'd9;
  localparam logic [7:0] ACT_TFF = 8'd255;

  localparam logic [7:0] SECOND_BYTE_MAX = 8'd15;
  localparam logic [7:0] TICK_MAX        = 8'd8;

  // a flag byte is good only when it is 0, 1, 16 or 17
  function automatic logic flag_value_bad(input logic [7:0] b);
    flag_value_bad = !((b == 8'd0) || (b == 8'd1) || (b == 8'd16) || (b == 8'd17));
  endfunction

endpackage

`default_nettype wire

// ===== src/upsc_rules.sv =====
// ----------------------------------------------------------------------------
// upsc_rules
// Per-action length and field rules, applied at the end of a packet.
// ----------------------------------------------------------------------------
`default_nettype none

module upsc_rules #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic [COUNT_WIDTH-1:0] len,
  input  wire upsc_pkg::upsc_flags_t  flags,
  output upsc_pkg::upsc_out_t         res
);
  import upsc_pkg::*;

  logic len_gt1;
  logic len_gt2;
  logic len_gt3;
  logic bad3;
  logic excl;
  logic det;
  logic [7:0] code;

  assign len_gt1 = len > COUNT_WIDTH'(1);
  assign len_gt2 = len > COUNT_WIDTH'(2);
  assign len_gt3 = len > COUNT_WIDTH'(3);
  assign bad3    = len_gt3 && flags.offset3_bad;

  always_comb begin
    excl = 1'b0;
    det  = 1'b0;
    code = flags.first_byte;
    if (!flags.udp_seen || (len == '0)) begin
      excl = 1'b1;
      code = 8'd0;
    end else begin
      unique case (flags.first_byte) inside
        ACT_T0: begin
          excl = len_gt1;
        end
        ACT_T1: begin
          excl = len_gt1;
          det  = !len_gt1;
        end
        ACT_T2: begin
          if (len[1:0] != 2'd1) begin
            excl = 1'b1;
          end else begin
            excl = flags.tick_field_bad;
            det  = 1'b1;
          end
        end
        ACT_T3: begin
          excl = len_gt2;
        end
        ACT_T4, ACT_T5: begin
          if ((len != COUNT_WIDTH'(10)) && (len != COUNT_WIDTH'(75))) begin
            excl = 1'b1;
          end else if (flags.offset8_bad) begin
            excl = 1'b1;
          end else begin
            det = 1'b1;
          end
        end
        ACT_T6: begin
          excl = len != COUNT_WIDTH'(7);
        end
        ACT_T7: begin
          excl = len != COUNT_WIDTH'(3);
        end
        ACT_T8: begin
          if (len[1:0] != 2'd3) begin
            excl = 1'b1;
          end else if (bad3) begin
            excl = 1'b1;
          end else begin
            det = 1'b1;
          end
        end
        ACT_T9: begin
          excl = ((len != COUNT_WIDTH'(3)) && (len != COUNT_WIDTH'(71))) || bad3;
          det  = !bad3;
        end
        ACT_TFF: begin
          if (len != COUNT_WIDTH'(2)) begin
            excl = 1'b1;
          end else if (flags.second_byte_large) begin
            excl = 1'b1;
          end else begin
            det = 1'b1;
          end
        end
        default: begin
          excl = 1'b0;
          det  = 1'b0;
        end
      endcase
    end
  end

  assign res = '{excluded: excl, detected: det, action_code: code};

endmodule

`default_nettype wire

// ===== src/udp_payload_signature_classifier_top.sv =====
// datapath: from item accept to result valid an item passes the input register, then the result register
// throughput: one item per cycle; stalls only when a last item meets a full result
//   register that is not being taken
// reset: synchronous rst clears the input and result valid bits, the byte count and
//   all per-packet flags
// ----------------------------------------------------------------------------
// udp_payload_signature_classifier_top
// Byte-serial udp payload classifier giving excluded and detected flags per packet.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_payload_signature_classifier_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire upsc_pkg::upsc_in_t item,
  output logic                result_valid,
  input  wire logic           result_ready,
  output upsc_pkg::upsc_out_t result
);
  import upsc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic                   pend_valid;
  upsc_in_t               pend;
  logic                   advance;
  logic                   out_free;

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  upsc_flags_t            flags;
  upsc_flags_t            flags_next;
  logic                   take;
  upsc_out_t              res_next;

  // input stage moves on unless a last item finds the result register occupied
  assign out_free   = !result_valid || result_ready;
  assign advance    = pend_valid && (!pend.last_byte || out_free);
  assign item_ready = !pend_valid || advance;

  assign take = pend.has_byte && (count != COUNT_MAX);

  always_comb begin
    flags_next = flags;
    count_next = count;
    if (count == '0) begin
      flags_next.udp_seen = pend.is_udp;
    end
    if (take) begin
      if (count == COUNT_WIDTH'(0)) begin
        flags_next.first_byte = pend.data_byte;
      end
      if (count == COUNT_WIDTH'(1)) begin
        flags_next.second_byte_large = pend.data_byte > SECOND_BYTE_MAX;
      end
      if (count == COUNT_WIDTH'(3)) begin
        flags_next.offset3_bad = flag_value_bad(pend.data_byte);
      end
      if (count == COUNT_WIDTH'(8)) begin
        flags_next.offset8_bad = flag_value_bad(pend.data_byte);
      end
      if ((count[1:0] == 2'd3) && (pend.data_byte > TICK_MAX)) begin
        flags_next.tick_field_bad = 1'b1;
      end
      count_next = count + COUNT_WIDTH'(1);
    end
  end

  upsc_rules #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_rules (
    .len   (count_next),
    .flags (flags_next),
    .res   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (item_ready) begin
      pend_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      pend <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      flags <= '0;
    end else if (advance) begin
      if (pend.last_byte) begin
        count <= '0;
        flags <= '0;
      end else begin
        count <= count_next;
        flags <= flags_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && pend.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pend.last_byte) begin
      result <= res_next;
    end
  end

  // a last item always leaves the tracker cleared for the next packet
  assert property (@(posedge clk) disable iff (rst)
    (advance && pend.last_byte) |=> (count == '0) && (flags == '0))
    else $error("tracker not cleared after last item");

  // a held input item is not overwritten while it waits
  assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !advance) |=> pend_valid && $stable(pend))
    else $error("held item lost");

  // a non-udp or empty packet reports excluded with a zero code
  assert property (@(posedge clk) disable iff (rst)
    (advance && pend.last_byte && (!flags_next.udp_seen || (count_next == '0)))
    |=> result.excluded && !result.detected && (result.action_code == 8'd0))
    else $error("non-udp or empty packet misreported");

  // the byte count never moves while the input stage is empty
  assert property (@(posedge clk) disable iff (rst)
    !pend_valid |=> $stable(count))
    else $error("count changed without an item");

endmodule

`default_nettype wire
